FILE: design/pnc_pkg.sv
// ----------------------------------------------------------------------------
// pnc_pkg
// Shared widths and limits for the perfect number checker and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package pnc_pkg;

  localparam int unsigned VALUE_WIDTH_DEF = 16;

  localparam int unsigned IN_VALUE_W  = 16;
  localparam int unsigned ECHO_W      = 16;
  localparam int unsigned SUM_W       = 18;
  localparam int unsigned IN_TDATA_W  = 16;
  localparam int unsigned OUT_FIELD_W = ECHO_W + SUM_W + 1;
  localparam int unsigned OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

endpackage

`default_nettype wire

FILE: design/perfect_number_check.sv
// ----------------------------------------------------------------------------
// perfect_number_check
// Aliquot sum and perfect number test, one item at a time.
// ----------------------------------------------------------------------------
// Each transfer on the input carries one unsigned number n (the low
// VALUE_WIDTH bits are used). The block walks trial divisors i = 1, 2, ...
// while i*i <= n, divides n by i on one shared restoring divider (one
// quotient bit per cycle), adds i and, when it differs from i, n/i to a
// running sum when the remainder is zero, and finally takes n off to leave
// the sum of the proper divisors. The result carries n, that sum (saturated
// at 18 bits) and a flag set when n is nonzero and equals the sum.
// in_tready is low from the accepted transfer until the result has been taken.
`default_nettype none

module perfect_number_check #(
  parameter int unsigned VALUE_WIDTH = pnc_pkg::VALUE_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [pnc_pkg::IN_TDATA_W-1:0]  in_tdata,   // [15:0] value
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  output      logic [pnc_pkg::OUT_TDATA_W-1:0] out_tdata   // [15:0] value_echo,
                                                          // [33:16] divisor_sum,
                                                          // [34] is_perfect, rest 0
);
  import pnc_pkg::*;

  localparam int unsigned W     = VALUE_WIDTH;
  localparam int unsigned ACC_W = W + 3;
  localparam int unsigned SQ_W  = W + 2;
  localparam int unsigned CNT_W = $clog2(W);
  localparam int unsigned CMP_W = (ACC_W > SUM_W) ? ACC_W : SUM_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_CHECK = 7'b0000010,
    S_DIV   = 7'b0000100,
    S_ADD_I = 7'b0001000,
    S_ADD_Q = 7'b0010000,
    S_FIN   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t             state_r, state_nxt;
  logic [W-1:0]       n_r, n_nxt;
  logic [W-1:0]       i_r, i_nxt;
  logic [SQ_W-1:0]    sq_r, sq_nxt;
  logic [ACC_W-1:0]   total_r, total_nxt;
  logic [W-1:0]       rem_r, rem_nxt;
  logic [W-1:0]       quo_r, quo_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [ECHO_W-1:0]  echo_r, echo_nxt;
  logic [SUM_W-1:0]   sum_r, sum_nxt;
  logic               perf_r, perf_nxt;

  logic [W:0]         trial;
  logic               fits;
  logic [ACC_W-1:0]   aliq;
  logic               sat;

  // One restoring division step: shift in the next dividend bit, subtract
  // the trial divisor when it fits.
  always_comb begin
    trial = {rem_r, quo_r[W-1]};
    fits  = (trial >= {1'b0, i_r});
  end

  assign aliq = total_r - ACC_W'(n_r);
  assign sat  = (CMP_W'(aliq) > CMP_W'(SUM_MAX));

  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    i_nxt     = i_r;
    sq_nxt    = sq_r;
    total_nxt = total_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    cnt_nxt   = cnt_r;
    echo_nxt  = echo_r;
    sum_nxt   = sum_r;
    perf_nxt  = perf_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          n_nxt     = W'(in_tdata[IN_VALUE_W-1:0]);
          i_nxt     = W'(1);
          sq_nxt    = SQ_W'(1);
          total_nxt = '0;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sq_r <= SQ_W'(n_r)) begin
          rem_nxt   = '0;
          quo_nxt   = n_r;
          cnt_nxt   = CNT_W'(W - 1);
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DIV: begin
        rem_nxt = fits ? W'(trial - {1'b0, i_r}) : W'(trial);
        quo_nxt = {quo_r[W-2:0], fits};
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = S_ADD_I;
        end
      end
      S_ADD_I: begin
        if (rem_r == '0) begin
          total_nxt = total_r + ACC_W'(i_r);
        end
        state_nxt = S_ADD_Q;
      end
      S_ADD_Q: begin
        // add the paired divisor unless it is the square root itself
        if (rem_r == '0 && quo_r != i_r) begin
          total_nxt = total_r + ACC_W'(quo_r);
        end
        sq_nxt    = sq_r + SQ_W'({i_r, 1'b1});
        i_nxt     = i_r + W'(1);
        state_nxt = S_CHECK;
      end
      S_FIN: begin
        echo_nxt  = ECHO_W'(n_r);
        sum_nxt   = sat ? SUM_MAX : SUM_W'(aliq);
        perf_nxt  = (n_r != '0) && (aliq == ACC_W'(n_r));
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_tready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    n_r     <= n_nxt;
    i_r     <= i_nxt;
    sq_r    <= sq_nxt;
    total_r <= total_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    echo_r  <= echo_nxt;
    sum_r   <= sum_nxt;
    perf_r  <= perf_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = OUT_TDATA_W'({perf_r, sum_r, echo_r});

endmodule

`default_nettype wire

FILE: design/pnc_checker.sv
// ----------------------------------------------------------------------------
// pnc_checker
// Port-level checks for the perfect number checker, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module pnc_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_tvalid,
  input wire logic                           in_tready,
  input wire logic [pnc_pkg::IN_TDATA_W-1:0]  in_tdata,
  input wire logic                           out_tvalid,
  input wire logic                           out_tready,
  input wire logic [pnc_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import pnc_pkg::*;

  logic [ECHO_W-1:0] echo;
  logic [SUM_W-1:0]  dsum;
  logic              perf;

  assign echo = out_tdata[ECHO_W-1:0];
  assign dsum = out_tdata[ECHO_W+SUM_W-1:ECHO_W];
  assign perf = out_tdata[ECHO_W+SUM_W];

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled result dropped or changed");

  // one item in flight: no input taken while a result is offered
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while result pending");

  // an accepted transfer closes the input straight away
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready straight after a transfer");

  // a perfect flag needs a nonzero value equal to its divisor sum
  a_perfect: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && perf |-> echo != '0 && dsum == SUM_W'(echo))
    else $error("perfect flag inconsistent with sum");

  // a taken result is not offered again
  a_out_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> !out_tvalid)
    else $error("result offered twice");

endmodule

bind perfect_number_check pnc_checker u_pnc_checker (.*);

`default_nettype wire
